// ----- rtl/core/van_leer_slope_limiter_unit_assert.svh -----
// Assertion macros shared by the slope limiter checkers.
// No dependencies; included by files that carry concurrent assertions.
`ifndef VAN_LEER_SLOPE_LIMITER_UNIT_ASSERT_SVH
`define VAN_LEER_SLOPE_LIMITER_UNIT_ASSERT_SVH

// Checked while out of reset
`define VLSL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define VLSL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/vlsl_pkg.sv -----
// Package for the van Leer slope limiter: payload types, widths, divider cell data.
// No dependencies.
package vlsl_pkg;

  localparam int ValW        = 32;
  localparam int PosW        = 24;
  localparam int PosFracBits = 24;
  localparam int QuotW       = 32;
  localparam int DiffW       = ValW + 1;
  localparam int DMagW       = ValW;
  localparam int HSW         = ((PosFracBits > PosW) ? PosFracBits : PosW) + 2;
  localparam int HMagW       = HSW - 1;
  localparam int PMagW       = DMagW + HMagW;
  localparam int NumW        = 2 * DMagW + PosFracBits + 1;
  localparam int DenW        = PMagW + 1;
  localparam int RemW        = ((NumW > DenW + QuotW) ? NumW : DenW + QuotW) + 1;

  typedef struct packed {
    logic signed [ValW-1:0] left_value;
    logic signed [ValW-1:0] center_value;
    logic signed [ValW-1:0] right_value;
    logic [PosW-1:0]        left_position;
    logic [PosW-1:0]        center_position;
    logic [PosW-1:0]        right_position;
  } vlsl_in_t;

  typedef struct packed {
    logic signed [ValW-1:0] limited_slope;
    logic                   slope_saturated;
  } vlsl_out_t;

  // Data handed along the divider chain
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [DenW-1:0]  den;
    logic [QuotW-1:0] quot;
    logic             neg;
    logic             kill;
    logic             ovf;
  } vlsl_div_t;

endpackage

// ----- rtl/core/vlsl_front.sv -----
// Front pipeline: differences, spacings, products, numerator, denominator and overflow test.
// Depends on vlsl_pkg.
module vlsl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vlsl_pkg::vlsl_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vlsl_pkg::vlsl_div_t out_data_o
);
  import vlsl_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  // stage 1 data
  logic [DMagW-1:0] dm1_q, dm2_q;
  logic [HMagW-1:0] hm1_q, hm2_q;
  logic             kill1_q, neg1_q;
  // stage 2 data
  logic [2*DMagW-1:0] pdd_q;
  logic [PMagW-1:0]   ph1_q, ph2_q;
  logic               kill2_q, neg2_q;
  // stage 3 data
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] den_q;
  logic            kill3_q, neg3_q;
  // stage 4 data
  vlsl_div_t       div_q;

  // stage enables: a stage loads when empty or when its content moves on
  assign r4 = !v4_q || out_ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o  = r1;
  assign out_valid_o = v4_q;
  assign out_data_o  = div_q;

  // differences and wrapped spacings
  logic signed [DiffW-1:0] vl, vc, vr, d1, d2, nd1, nd2;
  logic signed [HSW-1:0]   pl, pc, pr, one, h1, h2, nh1, nh2;
  logic                    kill_d, neg_d;
  always_comb begin
    vl  = {{(DiffW-ValW){in_data_i.left_value[ValW-1]}}, in_data_i.left_value};
    vc  = {{(DiffW-ValW){in_data_i.center_value[ValW-1]}}, in_data_i.center_value};
    vr  = {{(DiffW-ValW){in_data_i.right_value[ValW-1]}}, in_data_i.right_value};
    pl  = $signed({{(HSW-PosW){1'b0}}, in_data_i.left_position});
    pc  = $signed({{(HSW-PosW){1'b0}}, in_data_i.center_position});
    pr  = $signed({{(HSW-PosW){1'b0}}, in_data_i.right_position});
    one = $signed(HSW'(1) << PosFracBits);
    if (pr < pc) begin
      pr = pr + one;
    end
    if (pl > pc) begin
      pl = pl - one;
    end
    d1  = vc - vl;
    d2  = vr - vc;
    h1  = pc - pl;
    h2  = pr - pc;
    nd1 = -d1;
    nd2 = -d2;
    nh1 = -h1;
    nh2 = -h2;
    neg_d  = d1[DiffW-1] ^ h1[HSW-1];
    kill_d = (d1 == '0) || (d2 == '0) || (h1 == '0) || (h2 == '0) ||
             (neg_d != (d2[DiffW-1] ^ h2[HSW-1]));
  end

  // stage 1: magnitudes and special cases
  always_ff @(posedge clk_i) begin
    if (r1) begin
      dm1_q   <= d1[DiffW-1] ? nd1[DMagW-1:0] : d1[DMagW-1:0];
      dm2_q   <= d2[DiffW-1] ? nd2[DMagW-1:0] : d2[DMagW-1:0];
      hm1_q   <= h1[HSW-1] ? nh1[HMagW-1:0] : h1[HMagW-1:0];
      hm2_q   <= h2[HSW-1] ? nh2[HMagW-1:0] : h2[HMagW-1:0];
      kill1_q <= kill_d;
      neg1_q  <= neg_d;
    end
  end

  // stage 2: the three products
  always_ff @(posedge clk_i) begin
    if (r2) begin
      pdd_q   <= dm1_q * dm2_q;
      ph1_q   <= PMagW'(dm1_q) * PMagW'(hm2_q);
      ph2_q   <= PMagW'(dm2_q) * PMagW'(hm1_q);
      kill2_q <= kill1_q;
      neg2_q  <= neg1_q;
    end
  end

  // stage 3: denominator sum, scaled numerator
  always_ff @(posedge clk_i) begin
    if (r3) begin
      num_q   <= NumW'(pdd_q) << (PosFracBits + 1);
      den_q   <= DenW'(ph1_q) + DenW'(ph2_q);
      kill3_q <= kill2_q;
      neg3_q  <= neg2_q;
    end
  end

  // stage 4: quotient overflow test (q >= 2^32)
  always_ff @(posedge clk_i) begin
    if (r4) begin
      div_q.rem  <= RemW'(num_q);
      div_q.den  <= den_q;
      div_q.quot <= '0;
      div_q.neg  <= neg3_q;
      div_q.kill <= kill3_q;
      div_q.ovf  <= RemW'(num_q) >= (RemW'(den_q) << QuotW);
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

endmodule

// ----- rtl/core/vlsl_div_cell.sv -----
// One cell of the restoring divider chain: settles quotient bit BitPos.
// Depends on vlsl_pkg.
module vlsl_div_cell #(
  parameter int BitPos = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vlsl_pkg::vlsl_div_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vlsl_pkg::vlsl_div_t out_data_o
);
  import vlsl_pkg::*;

  logic      valid_q;
  vlsl_div_t data_q, data_d;
  logic [RemW-1:0] trial;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  // trial subtraction of the shifted divisor
  always_comb begin
    data_d = in_data_i;
    trial  = in_data_i.rem - (RemW'(in_data_i.den) << BitPos);
    if (!trial[RemW-1]) begin
      data_d.rem          = trial;
      data_d.quot[BitPos] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

endmodule

// ----- rtl/core/van_leer_slope_limiter_unit.sv -----
// Top level of the van Leer slope limiter: front pipeline, divider cell chain, output stage.
// Depends on vlsl_pkg, vlsl_front and vlsl_div_cell.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries three cell values (Q16.16) and their
//   positions (Q0.24) in a unit periodic domain; output channel out_valid_o/out_ready_i
//   carries the limited slope (Q16.16, saturated) and a saturation flag.
//   Throughput: one item per cycle, sustained, when the receiver keeps ready high.
//   Pipeline: 37 register stages: four front stages (differences, products, sum,
//   overflow test), 32 divider cells that each settle one quotient bit, and the
//   output register. The cell chain sets the latency.
//   Reset clears every valid flag; the data registers are not reset.
//   When the receiver stalls, the result waits in the output register and each stage
//   keeps loading until it holds an item, so bubbles close up before the input
//   channel drops ready.
module van_leer_slope_limiter_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vlsl_pkg::vlsl_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vlsl_pkg::vlsl_out_t out_data_o
);
  import vlsl_pkg::*;

  vlsl_div_t chain_data  [QuotW+1];
  logic      chain_valid [QuotW+1];
  logic      chain_ready [QuotW+1];

  logic      out_valid_q;
  vlsl_out_t out_q, out_d;
  logic      out_en;

  // front pipeline
  vlsl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_data_o  (chain_data[0])
  );

  // divider chain, most significant quotient bit first
  for (genvar k = 0; k < QuotW; k++) begin : g_cell
    vlsl_div_cell #(
      .BitPos (QuotW - 1 - k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_data_i   (chain_data[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_data_o  (chain_data[k+1])
    );
  end

  assign out_en             = !out_valid_q || out_ready_i;
  assign chain_ready[QuotW] = out_en;

  // sign and saturation
  logic [QuotW-1:0] q;
  logic             sat;
  always_comb begin
    q   = chain_data[QuotW].quot;
    sat = chain_data[QuotW].ovf ||
          (q[QuotW-1] && (!chain_data[QuotW].neg || (q[QuotW-2:0] != '0)));
    out_d = '0;
    if (!chain_data[QuotW].kill) begin
      if (sat) begin
        out_d.slope_saturated = 1'b1;
        out_d.limited_slope   = chain_data[QuotW].neg ? {1'b1, {(ValW-1){1'b0}}}
                                                      : {1'b0, {(ValW-1){1'b1}}};
      end else begin
        out_d.limited_slope = chain_data[QuotW].neg ? -$signed(ValW'(q)) : $signed(ValW'(q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= chain_valid[QuotW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/vlsl_checker.sv -----
// Port-level checker for the slope limiter, bound to the top level.
// Depends on vlsl_pkg and van_leer_slope_limiter_unit_assert.svh.
`include "van_leer_slope_limiter_unit_assert.svh"
module vlsl_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input vlsl_pkg::vlsl_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vlsl_pkg::vlsl_out_t out_data_o
);
  import vlsl_pkg::*;

  // no result during reset
  `VLSL_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !out_valid_o, "result valid in reset")

  // a stalled result holds
  `VLSL_ASSERT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  // a saturated result sits at one end of the range
  `VLSL_ASSERT(a_sat_ends, clk_i, rst_ni, out_valid_o && out_data_o.slope_saturated |-> (out_data_o.limited_slope == 32'sh7fffffff || out_data_o.limited_slope == 32'sh80000000), "saturated value not at a range end")

  // an empty output register never blocks the input
  `VLSL_ASSERT(a_no_block, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input blocked with output empty")

endmodule

bind van_leer_slope_limiter_unit vlsl_checker u_vlsl_checker (.*);
